// ----- design/ipd_frame_deframer_assert.svh -----
// assertion macros for the ipd deframer checker
// no dependencies; included by the checker file
`ifndef IPD_FRAME_DEFRAMER_ASSERT_SVH
`define IPD_FRAME_DEFRAMER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IPD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define IPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ipd_pkg.sv -----
// shared types, codes and constants of the ipd frame deframer
// no dependencies
`default_nettype none
package ipd_pkg;

   localparam int MAX_DIGITS  = 4;
   localparam int MAX_LINK_ID = 4;
   localparam int DCNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int NUM_W       = 14;
   localparam int ACC_W       = NUM_W + 4;
   localparam logic [NUM_W-1:0] NUM_CAP = NUM_W'(9999);
   localparam logic [2:0] MARKER_LEN = 3'd5;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HUNT = 3'd1;
   localparam logic [2:0] PH_NUM1 = 3'd2;
   localparam logic [2:0] PH_NUM2 = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_ID      = 3'd1;
   localparam logic [2:0] ST_BAD_LEN     = 3'd2;
   localparam logic [2:0] ST_HDR_TMO     = 3'd3;
   localparam logic [2:0] ST_PAYLOAD_TMO = 3'd4;

   localparam logic [1:0] CSR_HDR_TMO     = 2'd0;
   localparam logic [1:0] CSR_PAYLOAD_TMO = 2'd1;
   localparam logic [1:0] CSR_CAPACITY    = 2'd2;

   localparam logic [15:0] HDR_TMO_RESET     = 16'd1000;
   localparam logic [15:0] PAYLOAD_TMO_RESET = 16'd3000;
   localparam logic [15:0] CAPACITY_RESET    = 16'd1024;

   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;

   typedef struct packed {
      logic start;
      logic comma;
      logic neg;
      logic stop;
   } nflags_type;

   typedef struct packed {
      logic [NUM_W-1:0]  num;
      nflags_type        flags;
      logic [DCNT_W-1:0] dcnt;
   } num_state_type;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             is_payload;
      logic             last;
      logic [2:0]       status;
      logic [2:0]       link_id;
      logic             link_id_present;
      logic [NUM_W-1:0] announced_len;
   } rsp_type;

   function automatic logic [7:0] marker_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h2b;
         3'd1:    ch = 8'h49;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h44;
         3'd4:    ch = 8'h2c;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

// ----- design/ipd_num_unit.sv -----
// one byte step of the decimal number parser of the header
// depends on ipd_pkg
`default_nettype none
module ipd_num_unit
   import ipd_pkg::*;
(
   input  wire logic [7:0]    rx_byte,
   input  num_state_type      cur,
   output num_state_type      nxt
);

   logic             blank;
   logic             digit;
   logic [ACC_W-1:0] acc;

   assign blank = rx_byte inside {[8'd9:8'd13], 8'd32};
   assign digit = rx_byte inside {[8'h30:8'h39]};
   assign acc   = {cur.num, 3'b000} + {3'b000, cur.num, 1'b0}
                + ACC_W'(rx_byte[3:0]);

   always_comb begin
      nxt = cur;
      if (cur.flags.stop) begin
         nxt = cur;
      end else if (!cur.flags.start && blank) begin
         nxt = cur;
      end else if (!cur.flags.start && (rx_byte == CH_PLUS || rx_byte == CH_MINUS)) begin
         nxt.flags.start = 1'b1;
         if (rx_byte == CH_MINUS) begin
            nxt.flags.neg = 1'b1;
         end
      end else if (!digit) begin
         nxt.flags.stop  = 1'b1;
         nxt.flags.start = 1'b1;
      end else begin
         nxt.flags.start = 1'b1;
         if (cur.dcnt < DCNT_W'(MAX_DIGITS)) begin
            nxt.dcnt = cur.dcnt + DCNT_W'(1);
            nxt.num  = (acc > ACC_W'(NUM_CAP)) ? NUM_CAP : acc[NUM_W-1:0];
         end
      end
   end

endmodule
`default_nettype wire

// ----- design/ipd_frame_deframer.sv -----
// top level of the ipd frame deframer: header parser, payload counter, result queue
// depends on ipd_pkg and ipd_num_unit
//
// usage
//   req channel: one transaction per item, op start / serial byte / tick,
//     byte in req_rx_byte. start arms a receive and abandons any running one.
//   rsp channel: at most one result per item; payload bytes with status ok,
//     last set on the final byte, or one error / empty result with last set.
//   csr channel: writes header timeout, payload timeout and capacity by index;
//     always ready, to be written while no receive is in flight.
//   result path: each result is registered in the output register or skid.
//   throughput: one item per cycle while req_ready is high, all parsing
//     state updated in a single pass of logic into the result registers.
//   stall: a two-entry result queue (output register plus skid) lets one
//     more item in while a result waits; req_ready drops when both are full.
//   reset: synchronous, clears the parser to idle, empties the queue and
//     loads the registers with 1000, 3000 and 1024.
`default_nettype none
module ipd_frame_deframer
   import ipd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_op,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_is_payload,
   output logic                  rsp_last,
   output logic [2:0]            rsp_status,
   output logic [2:0]            rsp_link_id,
   output logic                  rsp_link_id_present,
   output logic [NUM_W-1:0]      rsp_announced_len,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   logic [15:0]       hdr_tmo_ff, payload_tmo_ff, capacity_ff;

   logic [2:0]        phase_ff, phase_in;
   logic [2:0]        pos_ff, pos_in;
   logic [15:0]       elapsed_ff, elapsed_in;
   num_state_type     num_ff, num_in;
   logic [NUM_W-1:0]  first_ff, first_in;
   logic [NUM_W-1:0]  delivered_ff, delivered_in;
   logic [NUM_W-1:0]  quota_ff, quota_in;
   logic [2:0]        hdr_id_ff, hdr_id_in;
   logic              hdr_present_ff, hdr_present_in;
   logic [NUM_W-1:0]  hdr_len_ff, hdr_len_in;

   rsp_type           out_ff, out_in, skid_ff, skid_in;
   logic              out_v_ff, out_v_in, skid_v_ff, skid_v_in;

   rsp_type           res;
   logic              res_v;
   logic              accept;
   logic              pop;
   num_state_type     num_step;
   logic              len_neg;
   logic              first_neg;
   logic [NUM_W-1:0]  len_sel;
   logic [NUM_W-1:0]  quota_calc;
   logic [15:0]       elapsed_inc;
   logic [NUM_W-1:0]  deliv_inc;

   assign accept    = req_valid && req_ready;
   assign pop       = out_v_ff && rsp_ready;
   assign req_ready = !skid_v_ff;
   assign csr_ready = 1'b1;

   ipd_num_unit u_num (
      .rx_byte (req_rx_byte),
      .cur     (num_ff),
      .nxt     (num_step)
   );

   assign len_sel     = num_ff.flags.comma ? num_ff.num : first_ff;
   assign len_neg     = num_ff.flags.neg && (len_sel != '0);
   assign first_neg   = num_ff.flags.neg && (num_ff.num != '0);
   assign quota_calc  = ({2'b00, len_sel} < capacity_ff) ? len_sel
                                                         : capacity_ff[NUM_W-1:0];
   assign elapsed_inc = (elapsed_ff == 16'hffff) ? elapsed_ff : elapsed_ff + 16'd1;
   assign deliv_inc   = delivered_ff + NUM_W'(1);

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      elapsed_in     = elapsed_ff;
      num_in         = num_ff;
      first_in       = first_ff;
      delivered_in   = delivered_ff;
      quota_in       = quota_ff;
      hdr_id_in      = hdr_id_ff;
      hdr_present_in = hdr_present_ff;
      hdr_len_in     = hdr_len_ff;
      res_v          = 1'b0;
      res            = '0;
      res.last       = 1'b1;
      res.link_id         = hdr_id_ff;
      res.link_id_present = hdr_present_ff;
      res.announced_len   = hdr_len_ff;
      if (accept) begin
         if (req_op == OP_START) begin
            phase_in       = PH_HUNT;
            pos_in         = '0;
            elapsed_in     = '0;
            num_in         = '0;
            first_in       = '0;
            delivered_in   = '0;
            quota_in       = '0;
            hdr_id_in      = '0;
            hdr_present_in = 1'b0;
            hdr_len_in     = '0;
         end else if (phase_ff != PH_IDLE && req_op == OP_TICK) begin
            elapsed_in = elapsed_inc;
            if (phase_ff == PH_DATA) begin
               if (elapsed_inc >= payload_tmo_ff) begin
                  phase_in   = PH_IDLE;
                  res_v      = 1'b1;
                  res.status = ST_PAYLOAD_TMO;
               end
            end else if (elapsed_inc >= hdr_tmo_ff) begin
               phase_in            = PH_IDLE;
               res_v               = 1'b1;
               res.status          = ST_HDR_TMO;
               res.link_id         = '0;
               res.link_id_present = 1'b0;
               res.announced_len   = '0;
            end
         end else if (phase_ff != PH_IDLE && req_op == OP_BYTE) begin
            case (phase_ff)
               PH_HUNT: begin
                  if (req_rx_byte == marker_char(pos_ff)) begin
                     pos_in = pos_ff + 3'd1;
                  end else begin
                     pos_in = (req_rx_byte == CH_PLUS) ? 3'd1 : 3'd0;
                  end
                  if (pos_in == MARKER_LEN) begin
                     phase_in = PH_NUM1;
                     num_in   = '0;
                  end
               end
               PH_NUM1, PH_NUM2: begin
                  if (req_rx_byte == CH_COLON) begin
                     if (num_ff.flags.comma && !hdr_present_ff) begin
                        phase_in            = PH_IDLE;
                        res_v               = 1'b1;
                        res.status          = ST_BAD_ID;
                        res.link_id         = '0;
                        res.link_id_present = 1'b0;
                        res.announced_len   = '0;
                     end else if (len_sel == '0 || len_neg) begin
                        phase_in          = PH_IDLE;
                        res_v             = 1'b1;
                        res.status        = ST_BAD_LEN;
                        res.announced_len = '0;
                     end else begin
                        hdr_len_in   = len_sel;
                        quota_in     = quota_calc;
                        delivered_in = '0;
                        elapsed_in   = '0;
                        if (quota_calc == '0) begin
                           phase_in          = PH_IDLE;
                           res_v             = 1'b1;
                           res.status        = ST_OK;
                           res.announced_len = len_sel;
                        end else begin
                           phase_in = PH_DATA;
                        end
                     end
                  end else if (phase_ff == PH_NUM1 && req_rx_byte == CH_COMMA) begin
                     if (!first_neg && (num_ff.num <= NUM_W'(MAX_LINK_ID))) begin
                        hdr_present_in = 1'b1;
                        hdr_id_in      = num_ff.num[2:0];
                     end else begin
                        hdr_present_in = 1'b0;
                        hdr_id_in      = '0;
                     end
                     first_in          = num_ff.num;
                     phase_in          = PH_NUM2;
                     num_in            = '0;
                     num_in.flags.comma = 1'b1;
                  end else begin
                     num_in = num_step;
                     if (phase_ff == PH_NUM1) begin
                        first_in = num_step.num;
                     end
                  end
               end
               PH_DATA: begin
                  delivered_in   = deliv_inc;
                  res_v          = 1'b1;
                  res.status     = ST_OK;
                  res.data_byte  = req_rx_byte;
                  res.is_payload = 1'b1;
                  res.last       = (deliv_inc >= quota_ff);
                  if (deliv_inc >= quota_ff) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // two-entry result queue
   always_comb begin
      out_in    = out_ff;
      skid_in   = skid_ff;
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_in    = skid_ff;
            out_v_in  = 1'b1;
            skid_in   = res;
            skid_v_in = res_v;
         end else begin
            out_in   = res;
            out_v_in = res_v;
         end
      end else if (res_v) begin
         skid_in   = res;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pos_ff         <= '0;
         elapsed_ff     <= '0;
         num_ff         <= '0;
         first_ff       <= '0;
         delivered_ff   <= '0;
         quota_ff       <= '0;
         hdr_id_ff      <= '0;
         hdr_present_ff <= 1'b0;
         hdr_len_ff     <= '0;
         out_v_ff       <= 1'b0;
         skid_v_ff      <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         elapsed_ff     <= elapsed_in;
         num_ff         <= num_in;
         first_ff       <= first_in;
         delivered_ff   <= delivered_in;
         quota_ff       <= quota_in;
         hdr_id_ff      <= hdr_id_in;
         hdr_present_ff <= hdr_present_in;
         hdr_len_ff     <= hdr_len_in;
         out_v_ff       <= out_v_in;
         skid_v_ff      <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_tmo_ff     <= HDR_TMO_RESET;
         payload_tmo_ff <= PAYLOAD_TMO_RESET;
         capacity_ff    <= CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HDR_TMO:     hdr_tmo_ff     <= csr_wdata;
            CSR_PAYLOAD_TMO: payload_tmo_ff <= csr_wdata;
            CSR_CAPACITY:    capacity_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_data_byte       = out_ff.data_byte;
   assign rsp_is_payload      = out_ff.is_payload;
   assign rsp_last            = out_ff.last;
   assign rsp_status          = out_ff.status;
   assign rsp_link_id         = out_ff.link_id;
   assign rsp_link_id_present = out_ff.link_id_present;
   assign rsp_announced_len   = out_ff.announced_len;

endmodule
`default_nettype wire

// ----- design/ipd_checker.sv -----
// port-level checker of the ipd frame deframer, bound to the top level
// depends on ipd_pkg and ipd_frame_deframer_assert.svh
`default_nettype none
`include "ipd_frame_deframer_assert.svh"
module ipd_checker
   import ipd_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [7:0]       rsp_data_byte,
   input wire logic             rsp_is_payload,
   input wire logic             rsp_last,
   input wire logic [2:0]       rsp_status,
   input wire logic [2:0]       rsp_link_id,
   input wire logic             rsp_link_id_present,
   input wire logic [NUM_W-1:0] rsp_announced_len
);

   `IPD_ASSERT_SAME(a_payload_ok, clock, reset, rsp_valid && rsp_is_payload, rsp_status == ST_OK, "payload transaction without ok status")

   `IPD_ASSERT_SAME(a_nonpayload_last, clock, reset, rsp_valid && !rsp_is_payload, rsp_last && rsp_data_byte == 8'd0, "non-payload result not last or carries data")

   `IPD_ASSERT_SAME(a_early_error_empty, clock, reset, rsp_valid && (rsp_status == ST_BAD_ID || rsp_status == ST_HDR_TMO), rsp_link_id == 3'd0 && !rsp_link_id_present && rsp_announced_len == '0, "header error carries header fields")

   `IPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_byte) && $stable(rsp_status) && $stable(rsp_last), "stalled result changed")

endmodule

bind ipd_frame_deframer ipd_checker u_ipd_checker (.*);
`default_nettype wire

// ----- tb/ipd_frame_checker.sv -----
`timescale 1ns / 1ps
// checker for the ipd frame deframer: watches the req, rsp and csr channels,
// predicts each result of the deframer and compares it field by field
// depends on ipd_pkg
module ipd_frame_checker
   import ipd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire logic [1:0]       req_op,
   input  wire logic [7:0]       req_rx_byte,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire logic [7:0]       rsp_data_byte,
   input  wire logic             rsp_is_payload,
   input  wire logic             rsp_last,
   input  wire logic [2:0]       rsp_status,
   input  wire logic [2:0]       rsp_link_id,
   input  wire logic             rsp_link_id_present,
   input  wire logic [NUM_W-1:0] rsp_announced_len,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata,
   output int                    outstanding,
   output int                    fail_count
);

   localparam logic [39:0] IPD_MARKER = "+IPD,";

   logic [15:0]       hdr_tmo_ticks;
   logic [15:0]       pay_tmo_ticks;
   logic [15:0]       payload_cap;
   logic [2:0]        rx_phase;
   logic [2:0]        marker_hits;
   logic [15:0]       tick_count;
   logic [NUM_W-1:0]  id_value;
   logic [NUM_W-1:0]  len_value;
   logic [DCNT_W-1:0] digits_taken;
   nflags_type        nflags;
   logic [15:0]       bytes_out;
   logic [15:0]       byte_quota;
   logic [2:0]        frame_id;
   logic              frame_id_ok;
   logic [NUM_W-1:0]  frame_len;

   rsp_type awaited_results[$];

   function automatic void clear_frame();
      marker_hits = '0;
      tick_count = '0;
      id_value = '0;
      len_value = '0;
      digits_taken = '0;
      nflags = '0;
      bytes_out = '0;
      byte_quota = '0;
      frame_id = '0;
      frame_id_ok = 1'b0;
      frame_len = '0;
   endfunction

   function automatic logic negative(input logic [NUM_W-1:0] v);
      return nflags.neg && (v != '0);
   endfunction

   function automatic logic [NUM_W-1:0] take_digit(input logic [NUM_W-1:0] num,
                                                   input logic [7:0] c);
      logic blank;
      logic digit;
      int   acc;
      blank = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
      digit = (c >= "0") && (c <= "9");
      if (nflags.stop) return num;
      if (!nflags.start) begin
         if (blank) return num;
         if (c == CH_PLUS || c == CH_MINUS) begin
            nflags.start = 1'b1;
            if (c == CH_MINUS) nflags.neg = 1'b1;
            return num;
         end
      end
      if (!digit) begin
         nflags.stop = 1'b1;
         nflags.start = 1'b1;
         return num;
      end
      nflags.start = 1'b1;
      if (digits_taken >= MAX_DIGITS) return num;
      digits_taken++;
      acc = int'(num) * 10 + int'(c - 8'h30);
      if (acc > int'(NUM_CAP)) acc = int'(NUM_CAP);
      return NUM_W'(acc);
   endfunction

   // colon seen: validate the header and enter the payload, or end with a result
   function automatic logic finish_header(output rsp_type r);
      logic [NUM_W-1:0] len;
      r = '0;
      r.last = 1'b1;
      if (nflags.comma) begin
         if (!frame_id_ok) begin
            rx_phase = PH_IDLE;
            r.status = ST_BAD_ID;
            return 1'b1;
         end
         len = len_value;
      end else begin
         len = id_value;
      end
      r.link_id = frame_id;
      r.link_id_present = frame_id_ok;
      if (len == '0 || negative(len)) begin
         rx_phase = PH_IDLE;
         r.status = ST_BAD_LEN;
         return 1'b1;
      end
      frame_len = len;
      byte_quota = (16'(len) < payload_cap) ? 16'(len) : payload_cap;
      bytes_out = '0;
      tick_count = '0;
      if (byte_quota == '0) begin
         rx_phase = PH_IDLE;
         r.status = ST_OK;
         r.announced_len = frame_len;
         return 1'b1;
      end
      rx_phase = PH_DATA;
      return 1'b0;
   endfunction

   function automatic logic deframe_item(input logic [1:0] op, input logic [7:0] c,
                                         output rsp_type r);
      logic id_good;
      r = '0;
      if (op == OP_START) begin
         clear_frame();
         rx_phase = PH_HUNT;
         return 1'b0;
      end
      if (rx_phase == PH_IDLE) return 1'b0;
      if (op == OP_TICK) begin
         if (tick_count != 16'hffff) tick_count++;
         if (rx_phase == PH_DATA) begin
            if (tick_count >= pay_tmo_ticks) begin
               rx_phase = PH_IDLE;
               r.last = 1'b1;
               r.status = ST_PAYLOAD_TMO;
               r.link_id = frame_id;
               r.link_id_present = frame_id_ok;
               r.announced_len = frame_len;
               return 1'b1;
            end
         end else if (tick_count >= hdr_tmo_ticks) begin
            rx_phase = PH_IDLE;
            r.last = 1'b1;
            r.status = ST_HDR_TMO;
            return 1'b1;
         end
         return 1'b0;
      end
      if (op != OP_BYTE) return 1'b0;
      case (rx_phase)
         PH_HUNT: begin
            if (marker_hits < MARKER_LEN && c == IPD_MARKER[39 - 8*marker_hits -: 8])
               marker_hits++;
            else
               marker_hits = (c == CH_PLUS) ? 3'd1 : 3'd0;
            if (marker_hits >= MARKER_LEN) begin
               rx_phase = PH_NUM1;
               id_value = '0;
               digits_taken = '0;
               nflags = '0;
            end
            return 1'b0;
         end
         PH_NUM1: begin
            if (c == CH_COLON) return finish_header(r);
            if (c == CH_COMMA) begin
               id_good = !negative(id_value) && (id_value <= MAX_LINK_ID);
               frame_id_ok = id_good;
               frame_id = id_good ? id_value[2:0] : 3'd0;
               rx_phase = PH_NUM2;
               len_value = '0;
               digits_taken = '0;
               nflags = '0;
               nflags.comma = 1'b1;
               return 1'b0;
            end
            id_value = take_digit(id_value, c);
            return 1'b0;
         end
         PH_NUM2: begin
            if (c == CH_COLON) return finish_header(r);
            len_value = take_digit(len_value, c);
            return 1'b0;
         end
         PH_DATA: begin
            bytes_out++;
            r.data_byte = c;
            r.is_payload = 1'b1;
            r.status = ST_OK;
            r.link_id = frame_id;
            r.link_id_present = frame_id_ok;
            r.announced_len = frame_len;
            if (bytes_out >= byte_quota) begin
               rx_phase = PH_IDLE;
               r.last = 1'b1;
            end
            return 1'b1;
         end
         default: begin
            rx_phase = PH_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input int want, input int seen);
      if (want != seen) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type seen;
      rsp_type pred;
      if (reset) begin
         hdr_tmo_ticks = HDR_TMO_RESET;
         pay_tmo_ticks = PAYLOAD_TMO_RESET;
         payload_cap = CAPACITY_RESET;
         rx_phase = PH_IDLE;
         clear_frame();
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HDR_TMO:     hdr_tmo_ticks = csr_wdata;
               CSR_PAYLOAD_TMO: pay_tmo_ticks = csr_wdata;
               CSR_CAPACITY:    payload_cap = csr_wdata;
               default: ;
            endcase
         end
         // this edge's req result is registered, so rsp is checked first
         if (rsp_valid && rsp_ready) begin
            seen.data_byte = rsp_data_byte;
            seen.is_payload = rsp_is_payload;
            seen.last = rsp_last;
            seen.status = rsp_status;
            seen.link_id = rsp_link_id;
            seen.link_id_present = rsp_link_id_present;
            seen.announced_len = rsp_announced_len;
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $time, seen);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("data_byte", int'(want.data_byte), int'(seen.data_byte));
               check_field("is_payload", int'(want.is_payload), int'(seen.is_payload));
               check_field("last", int'(want.last), int'(seen.last));
               check_field("status", int'(want.status), int'(seen.status));
               check_field("link_id", int'(want.link_id), int'(seen.link_id));
               check_field("link_id_present", int'(want.link_id_present),
                           int'(seen.link_id_present));
               check_field("announced_len", int'(want.announced_len),
                           int'(seen.announced_len));
            end
         end
         if (req_valid && req_ready) begin
            if (deframe_item(req_op, req_rx_byte, pred)) awaited_results.push_back(pred);
         end
      end
      outstanding <= awaited_results.size();
   end

endmodule

// ----- tb/tb_ipd_frame_deframer.sv -----
`timescale 1ns / 1ps
// top of the ipd frame deframer testbench: clock, reset, stimulus and verdict
// depends on ipd_pkg, ipd_frame_deframer and ipd_frame_checker
module tb_ipd_frame_deframer;
   import ipd_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int         MAX_WAIT   = 13;
   localparam int         RUN_LIMIT  = 600000;
   localparam int         PHASE_ITEMS = 240;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_op = OP_START;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready = 1'b1;
   logic [7:0]       rsp_data_byte;
   logic             rsp_is_payload;
   logic             rsp_last;
   logic [2:0]       rsp_status;
   logic [2:0]       rsp_link_id;
   logic             rsp_link_id_present;
   logic [NUM_W-1:0] rsp_announced_len;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = CSR_HDR_TMO;
   logic [15:0]      csr_wdata = 16'h0000;

   int   outstanding;
   int   fail_count;
   int   cycle_count = 0;
   int   items_sent = 0;
   int   tick_pct = 0;
   int   rsp_stall = 0;
   logic calm = 1'b0;

   ipd_frame_deframer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_is_payload      (rsp_is_payload),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .rsp_link_id         (rsp_link_id),
      .rsp_link_id_present (rsp_link_id_present),
      .rsp_announced_len   (rsp_announced_len),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   ipd_frame_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_is_payload      (rsp_is_payload),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .rsp_link_id         (rsp_link_id),
      .rsp_link_id_present (rsp_link_id_present),
      .rsp_announced_len   (rsp_announced_len),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .outstanding         (outstanding),
      .fail_count          (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("[ipd_frame_deframer] ERROR");
         $finish;
      end
   end

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // receiver may stall after each accepted result transaction, for a random wait
   always @(posedge clock) begin : rsp_pace
      int n;
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= (rsp_stall == 1);
      end else if (rsp_valid && rsp_ready) begin
         n = draw_wait();
         rsp_stall <= n;
         rsp_ready <= (n == 0);
      end
   end

   task automatic send_req(input logic [1:0] op, input logic [7:0] b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_serial(input logic [7:0] b);
      if ($urandom_range(0, 99) < tick_pct) send_req(OP_TICK, 8'($urandom));
      send_req(OP_BYTE, b);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_serial(s[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // a short complete frame always brings the parser back to idle
   task automatic close_receive();
      tick_pct = 0;
      send_req(OP_START, 8'($urandom));
      send_text("+IPD,1:");
      send_req(OP_BYTE, 8'($urandom));
   endtask

   task automatic configure(input logic [15:0] hdr, input logic [15:0] pay,
                            input logic [15:0] cap);
      close_receive();
      drain();
      write_csr(CSR_HDR_TMO, hdr);
      write_csr(CSR_PAYLOAD_TMO, pay);
      write_csr(CSR_CAPACITY, cap);
      write_csr(CSR_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic string number_text(input int value);
      string s;
      string blanks;
      int    k;
      blanks = " \t\n\013\014\015";
      s = "";
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            k = $urandom_range(0, 5);
            s = {s, blanks.substr(k, k)};
         end
      end
      case ($urandom_range(0, 19))
         0, 1: s = {s, "+"};
         2: s = {s, "-"};
         3: s = {s, "+-"};
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0) s = {s, "00"};
      if ($urandom_range(0, 24) != 0) s = {s, $sformatf("%0d", value)};
      case ($urandom_range(0, 19))
         0: s = {s, " 7"};
         1: s = {s, "x3"};
         2: s = {s, "-"};
         default: ;
      endcase
      return s;
   endfunction

   task automatic random_frame();
      int id_num;
      int len_num;
      int n;
      case ($urandom_range(0, 7))
         0, 1, 2: tick_pct = 0;
         3, 4:    tick_pct = 3;
         5, 6:    tick_pct = 10;
         default: tick_pct = 40;
      endcase
      calm <= ($urandom_range(0, 4) == 0);
      send_req(OP_START, 8'($urandom));
      case ($urandom_range(0, 5))
         0: send_text("+IP");
         1: repeat ($urandom_range(1, 4)) send_serial(8'($urandom));
         2: send_text("++");
         default: ;
      endcase
      if ($urandom_range(0, 19) == 0) send_text("+IPX,");
      else send_text("+IPD,");
      if ($urandom_range(0, 2) != 0) begin
         case ($urandom_range(0, 9))
            0:       id_num = $urandom_range(5, 99);
            1:       id_num = $urandom_range(100, 99999);
            default: id_num = $urandom_range(0, MAX_LINK_ID);
         endcase
         send_text(number_text(id_num));
         send_serial(CH_COMMA);
      end
      case ($urandom_range(0, 19))
         0, 1:    len_num = 0;
         2, 3:    len_num = $urandom_range(13, 40);
         4:       len_num = $urandom_range(41, 99999);
         default: len_num = $urandom_range(1, 12);
      endcase
      send_text(number_text(len_num));
      if ($urandom_range(0, 15) != 0) send_serial(CH_COLON);
      if (len_num > 40) begin
         n = $urandom_range(0, 40);
      end else begin
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(0, len_num);
            1:       n = len_num + $urandom_range(1, 3);
            default: n = len_num;
         endcase
      end
      repeat (n) send_serial(8'($urandom));
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 12)) send_req(OP_TICK, 8'($urandom));
   endtask

   task automatic run_phase();
      int stop_at;
      int half;
      stop_at = items_sent + PHASE_ITEMS;
      half = items_sent + PHASE_ITEMS / 2;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8)) send_req(2'($urandom_range(0, 3)), 8'($urandom));
         else
            random_frame();
         if (half != 0 && items_sent >= half) begin
            drain();
            half = 0;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // nothing armed: byte, tick and unknown op are dropped
      send_req(OP_BYTE, 8'hff);
      send_req(OP_TICK, 8'h00);
      send_req(OP_UNUSED, 8'ha5);
      send_req(OP_START, 8'h5a);
      send_text("+IPD,4,1:");
      send_req(OP_BYTE, 8'h00);
      send_req(OP_BYTE, 8'hff);
      send_req(OP_START, 8'h00);
      send_text("+IPD,:");

      configure(16'd1, 16'd1, 16'd1);
      run_phase();
      configure(16'hffff, 16'hffff, 16'hffff);
      run_phase();
      configure(16'd6, 16'd9, 16'd4);
      run_phase();
      configure(16'd0, 16'd0, 16'd0);
      run_phase();
      configure(16'd40, 16'd25, 16'd16);
      run_phase();
      configure(16'($urandom_range(2, 30)), 16'($urandom_range(2, 40)),
                16'($urandom_range(1, 20)));
      run_phase();

      drain();
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("[ipd_frame_deframer] OK");
      else
         $display("[ipd_frame_deframer] ERROR");
      $finish;
   end

endmodule
